>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/crc64rd_pkg.sv
// ----------------------------------------------------------------------------
// crc64rd_pkg
// word types, op codes, constants and the byte-wise crc table
// ----------------------------------------------------------------------------
`default_nettype none

package crc64rd_pkg;

    localparam logic [2:0] OP_BYTE  = 3'd0;
    localparam logic [2:0] OP_ELEM  = 3'd1;
    localparam logic [2:0] OP_NULL  = 3'd2;
    localparam logic [2:0] OP_ROW   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [63:0] CRC_POLY     = 64'h42F0_E1EB_A9EA_3693;
    localparam logic [63:0] CRC_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIX_P        = 64'd3860031;
    localparam logic [11:0] MIX_Q        = 12'd2779;
    localparam logic [1:0]  MIX_R        = 2'd2;
    localparam logic [7:0]  TAG_SEP      = 8'hFF;
    localparam logic [7:0]  TAG_NULL     = 8'hFE;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest;
        logic        has_data;
    } out_word_t;

    typedef enum logic [2:0] {
        K_FEED,
        K_NULL,
        K_ROW,
        K_CLEAR,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] feed_byte;
    } cmd_t;

    typedef logic [63:0] crc_table_t [256];

    function automatic crc_table_t crc_build_table();
        crc_table_t  t;
        logic [63:0] r;
        for (int i = 0; i < 256; i++)
        begin
            r = 64'(i) << 56;
            for (int b = 0; b < 8; b++)
            begin
                if (r[63])
                begin
                    r = (r << 1) ^ CRC_POLY;
                end
                else
                begin
                    r = r << 1;
                end
            end
            t[i] = r;
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_build_table();

    function automatic logic [63:0] crc_update(input logic [63:0] crc,
                                               input logic [7:0] b);
        logic [7:0] idx;
        idx = crc[63:56] ^ b;
        return {crc[55:0], 8'h00} ^ CRC_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

>>> rtl/crc64_row_digest_combiner_unit.sv
// ----------------------------------------------------------------------------
// crc64_row_digest_combiner_unit
// crc-64 row checksum with order-dependent row digest; when the back end is not held, one word per cycle
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the result queue has space; a null
//   element and a row fold after the first row hold the back end in further
//   states (ST_NULL2; ST_MUL, ST_SUM, ST_FIN), the fold set by the 32-bit
//   partial product chain
// reset: rst_n sets the crc to all ones and clears the digest, row flag and both queues at once
`default_nettype none

`include "assert_macros.svh"

module crc64_row_digest_combiner_unit
    import crc64rd_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 4,
    parameter int RESULT_DEPTH = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t request,
    output logic          empty,
    input  wire logic     pop,
    output out_word_t     result
);

    logic                         cmd_valid;
    cmd_t                         cmd;
    logic                         cmd_pop;
    logic                         res_full;
    logic                         res_push;
    out_word_t                    res_word;
    logic [$bits(out_word_t)-1:0] res_rd_data;

    crc64rd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    crc64rd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_space (!res_full),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    crc64rd_fifo #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = out_word_t'(res_rd_data);

    `ASSERT_NEVER(a_res_overflow, clk, rst_n, res_push && res_full, "result word lost on full queue")
    `ASSERT_NEVER(a_cmd_underflow, clk, rst_n, cmd_pop && !cmd_valid, "command popped from empty queue")
    `ASSERT_ALWAYS(a_clear_digest, clk, rst_n, (!empty && !result.has_data) |-> (result.digest == 64'h0), "digest nonzero without row")

endmodule

`default_nettype wire

>>> rtl/crc64rd_fifo.sv
// ----------------------------------------------------------------------------
// crc64rd_fifo
// small register queue with the head word always on the read port
// ----------------------------------------------------------------------------
`default_nettype none

module crc64rd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/crc64rd_front.sv
// ----------------------------------------------------------------------------
// crc64rd_front
// accepts input words, decodes the op and queues commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module crc64rd_front
    import crc64rd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_word_t request,
    output logic          full,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  wire logic     cmd_pop
);

    cmd_t                    cmd_in;
    logic                    q_empty;
    logic [$bits(cmd_t)-1:0] q_rd_data;

    always_comb
    begin
        cmd_in.feed_byte = request.data_byte;
        case (request.op)
            OP_BYTE:
            begin
                cmd_in.kind = K_FEED;
            end
            OP_ELEM:
            begin
                cmd_in.kind      = K_FEED;
                cmd_in.feed_byte = TAG_SEP;
            end
            OP_NULL:
            begin
                cmd_in.kind      = K_NULL;
                cmd_in.feed_byte = TAG_NULL;
            end
            OP_ROW:
            begin
                cmd_in.kind = K_ROW;
            end
            OP_CLEAR:
            begin
                cmd_in.kind = K_CLEAR;
            end
            default:
            begin
                cmd_in.kind = K_NOP;
            end
        endcase
    end

    crc64rd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = cmd_t'(q_rd_data);

endmodule

`default_nettype wire

>>> rtl/crc64rd_back.sv
// ----------------------------------------------------------------------------
// crc64rd_back
// crc register, row fold sequencer and digest state
// ----------------------------------------------------------------------------
`default_nettype none

module crc64rd_back
    import crc64rd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    input  wire logic res_space,
    output logic      res_push,
    output out_word_t res_word
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_NULL2,
        ST_MUL,
        ST_SUM,
        ST_FIN
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] crc_reg, crc_next;
    logic [63:0] digest_reg, digest_next;
    logic        seen_reg, seen_next;

    logic [63:0] h_reg, h_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] lin_reg, lin_next;

    always_comb
    begin
        state_next  = state_reg;
        crc_next    = crc_reg;
        digest_next = digest_reg;
        seen_next   = seen_reg;
        h_next      = h_reg;
        d_next      = d_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        lin_next    = lin_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (cmd_valid && res_space)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        K_FEED:
                        begin
                            crc_next = crc_update(crc_reg, cmd.feed_byte);
                            res_push = 1'b1;
                        end
                        K_NULL:
                        begin
                            crc_next   = crc_update(crc_reg, cmd.feed_byte);
                            state_next = ST_NULL2;
                        end
                        K_ROW:
                        begin
                            crc_next = CRC_ALL_ONES;
                            if (seen_reg)
                            begin
                                h_next     = digest_reg;
                                d_next     = crc_reg ^ CRC_ALL_ONES;
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                digest_next = crc_reg ^ CRC_ALL_ONES;
                                seen_next   = 1'b1;
                                res_push    = 1'b1;
                            end
                        end
                        K_CLEAR:
                        begin
                            crc_next    = CRC_ALL_ONES;
                            digest_next = '0;
                            seen_next   = 1'b0;
                            res_push    = 1'b1;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_NULL2:
            begin
                if (res_space)
                begin
                    crc_next   = crc_update(crc_reg, TAG_SEP);
                    res_push   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_MUL:
            begin
                // low 64 bits of h*d from 32-bit partial products
                p0_next    = {32'h0, h_reg[31:0]} * {32'h0, d_reg[31:0]};
                p1_next    = h_reg[31:0] * d_reg[63:32];
                p2_next    = h_reg[63:32] * d_reg[31:0];
                sum_next   = h_reg + d_reg;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                prod_next  = p0_reg + {p1_reg + p2_reg, 32'h0};
                lin_next   = sum_reg * 64'(MIX_Q);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (res_space)
                begin
                    digest_next = MIX_P + lin_reg + prod_reg * 64'(MIX_R);
                    res_push    = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        res_word.digest   = digest_next;
        res_word.has_data = seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            crc_reg    <= CRC_ALL_ONES;
            digest_reg <= '0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            crc_reg    <= crc_next;
            digest_reg <= digest_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        d_reg    <= d_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        lin_reg  <= lin_next;
    end

endmodule

`default_nettype wire
